[rtl/core/decimal_literal_parser_top_macros.svh]
// ----------------------------------------------------------------------------
// Decimal literal parser assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_LITERAL_PARSER_TOP_MACROS_SVH
`define DECIMAL_LITERAL_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent true implies consequent in the same cycle.
`define DLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decimal literal parser assertion failed");

// Antecedent true implies consequent in the following cycle.
`define DLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decimal literal parser assertion failed");

`else

`define DLP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/dlp_pkg.sv]
// ----------------------------------------------------------------------------
// Decimal literal parser package
// Field widths, character codes, parse phases, error codes and flag types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlp_pkg;

    localparam int DLP_COUNT_BITS = 32;

    localparam int CHAR_W = 8;
    localparam int ERR_W  = 4;
    localparam int COEF_W = 63;
    localparam int EXP_W  = 64;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;

    // Exponent character count saturates here; only zero, one and many matter.
    localparam logic [1:0] EXP_CNT_ONE  = 2'd1;
    localparam logic [1:0] EXP_CNT_MANY = 2'd2;

    typedef enum logic [1:0] {
        PHASE_INT,
        PHASE_FRAC,
        PHASE_EXP
    } dlp_phase_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK,
        ERR_EMPTY_SIGN,
        ERR_MULTI_EXP,
        ERR_BAD_EXP,
        ERR_EMPTY_EXP,
        ERR_MULTI_POINT,
        ERR_INCOMPLETE,
        ERR_NONDIGIT,
        ERR_ZERO,
        ERR_COEF_RANGE,
        ERR_EXP_RANGE
    } dlp_err_t;

    typedef struct packed {
        logic sign;
        logic multi_exp;
        logic bad_exp;
        logic multi_point;
        logic nondigit;
    } dlp_flags_t;

endpackage

[rtl/core/dlp_char_if.sv]
// ----------------------------------------------------------------------------
// Decimal literal parser character channel
// Valid/ready channel carrying one character beat of a literal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dlp_char_if import dlp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic              is_empty;
    logic              zero_allowed;

    modport source (
        output valid, char_code, is_last, is_empty, zero_allowed,
        input  ready
    );

    modport sink (
        input  valid, char_code, is_last, is_empty, zero_allowed,
        output ready
    );

endinterface

[rtl/core/dlp_result_if.sv]
// ----------------------------------------------------------------------------
// Decimal literal parser result channel
// Valid/ready channel carrying one parsed literal or its error code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dlp_result_if import dlp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ERR_W-1:0]  err_code;
    logic [COEF_W-1:0] coefficient;
    logic signed [EXP_W-1:0] exponent;

    modport source (
        output valid, err_code, coefficient, exponent,
        input  ready
    );

    modport sink (
        input  valid, err_code, coefficient, exponent,
        output ready
    );

endinterface

[rtl/core/decimal_literal_parser_top.sv]
// ----------------------------------------------------------------------------
// Decimal literal parser
// Streams one literal a character per beat and emits its value or an error.
// ----------------------------------------------------------------------------
// The block accepts one character beat per cycle unless a closing beat must
// wait for a full finish stage, and emits one result beat for each literal,
// on the beat marked last or empty. A beat passes through an input register,
// then a parse stage that updates the running coefficient, fraction count,
// exponent and sticky error flags with one times-ten accumulate, then a
// finish stage that ranks the errors and forms the final exponent, and
// finally the result register. A new literal may start on the very next
// beat. The result register decouples the two sides: while a result waits
// for the sink, character beats keep flowing until a second finished
// literal would need the finish stage. Error codes follow the check order
// empty/sign, multiple exponents, bad exponent, empty exponent, multiple
// points, incomplete mantissa, nondigit, zero, coefficient range, exponent
// range; coefficient and exponent read zero on any error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_literal_parser_top_macros.svh"

module decimal_literal_parser_top
    import dlp_pkg::*;
#(
    parameter int COUNT_BITS = DLP_COUNT_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    dlp_char_if.sink     chars,
    dlp_result_if.source results
);

    localparam int COEF_X_W = COEF_W + 5;
    localparam int EXP_X_W  = EXP_W + 4;

    // Input register stage.
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              in_empty_reg;
    logic              in_zero_reg;

    // Running parse state.
    logic                  first_reg;
    dlp_phase_t            phase_reg;
    logic                  point_reg;
    logic                  int_nz_reg;
    logic [COUNT_BITS-1:0] frac_reg;
    logic [COEF_W-1:0]     coef_reg;
    logic                  coef_ovf_reg;
    logic [EXP_W-1:0]      exp_mag_reg;
    logic                  exp_neg_reg;
    logic [1:0]            exp_cnt_reg;
    dlp_flags_t            flags_reg;

    // Snapshot of a finished literal for the finish stage.
    logic                  fin_valid_reg;
    logic                  fin_first_reg;
    dlp_phase_t            fin_phase_reg;
    logic                  fin_point_reg;
    logic                  fin_int_nz_reg;
    logic [COUNT_BITS-1:0] fin_frac_reg;
    logic [COEF_W-1:0]     fin_coef_reg;
    logic                  fin_coef_ovf_reg;
    logic [EXP_W-1:0]      fin_exp_mag_reg;
    logic                  fin_exp_neg_reg;
    logic [1:0]            fin_exp_cnt_reg;
    dlp_flags_t            fin_flags_reg;
    logic                  fin_zero_reg;

    // Result register.
    logic                    res_valid_reg;
    logic [ERR_W-1:0]        res_err_reg;
    logic [COEF_W-1:0]       res_coef_reg;
    logic signed [EXP_W-1:0] res_exp_reg;

    // Handshake between stages.
    logic out_free;
    logic fin_free;
    logic upd_ends;
    logic upd_fire;
    logic in_fire;

    assign out_free     = !res_valid_reg || results.ready;
    assign fin_free     = !fin_valid_reg || out_free;
    assign upd_ends     = in_last_reg || in_empty_reg;
    assign upd_fire     = in_valid_reg && (!upd_ends || fin_free);
    assign chars.ready  = !in_valid_reg || upd_fire;
    assign in_fire      = chars.valid && chars.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (upd_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_char_reg  <= chars.char_code;
            in_last_reg  <= chars.is_last;
            in_empty_reg <= chars.is_empty;
            in_zero_reg  <= chars.zero_allowed;
        end
    end

    // ------------------------------------------------------------------
    // Parse stage: fold one character into the running state.
    // ------------------------------------------------------------------
    logic                  is_digit;
    logic [3:0]            digit_val;
    logic [COEF_X_W-1:0]   coef_x10;
    logic [EXP_X_W-1:0]    exp_x10;
    logic [EXP_X_W-1:0]    exp_lim;
    logic                  coef_fits;
    logic                  exp_fits;
    logic [COUNT_BITS-1:0] frac_inc;
    logic [1:0]            exp_cnt_inc;

    logic                  first_next;
    dlp_phase_t            phase_next;
    logic                  point_next;
    logic                  int_nz_next;
    logic [COUNT_BITS-1:0] frac_next;
    logic [COEF_W-1:0]     coef_next;
    logic                  coef_ovf_next;
    logic [EXP_W-1:0]      exp_mag_next;
    logic                  exp_neg_next;
    logic [1:0]            exp_cnt_next;
    dlp_flags_t            flags_next;

    assign is_digit  = (in_char_reg >= CH_0) && (in_char_reg <= CH_9);
    assign digit_val = is_digit ? in_char_reg[3:0] : 4'd0;

    assign coef_x10 = ({5'd0, coef_reg} << 3) + ({5'd0, coef_reg} << 1)
                    + {{(COEF_X_W-4){1'b0}}, digit_val};
    assign coef_fits = (coef_x10[COEF_X_W-1:COEF_W] == '0);

    assign exp_x10 = ({4'd0, exp_mag_reg} << 3) + ({4'd0, exp_mag_reg} << 1)
                   + {{(EXP_X_W-4){1'b0}}, digit_val};
    // A negative exponent may reach one more in magnitude than a positive one.
    assign exp_lim = exp_neg_reg ? {4'd0, 1'b1, {(EXP_W-1){1'b0}}}
                                 : {5'd0, {(EXP_W-1){1'b1}}};
    assign exp_fits = (exp_x10 <= exp_lim);

    assign frac_inc    = (frac_reg == '1) ? frac_reg : frac_reg + 1'b1;
    assign exp_cnt_inc = (exp_cnt_reg == EXP_CNT_MANY) ? EXP_CNT_MANY
                                                       : exp_cnt_reg + 2'd1;

    always_comb
    begin
        first_next    = first_reg;
        phase_next    = phase_reg;
        point_next    = point_reg;
        int_nz_next   = int_nz_reg;
        frac_next     = frac_reg;
        coef_next     = coef_reg;
        coef_ovf_next = coef_ovf_reg;
        exp_mag_next  = exp_mag_reg;
        exp_neg_next  = exp_neg_reg;
        exp_cnt_next  = exp_cnt_reg;
        flags_next    = flags_reg;

        if (!in_empty_reg)
        begin
            if (first_reg)
            begin
                first_next = 1'b0;
                if ((in_char_reg == CH_PLUS) || (in_char_reg == CH_MINUS))
                begin
                    flags_next.sign = 1'b1;
                end
            end

            priority if ((in_char_reg == CH_E_LO) || (in_char_reg == CH_E_UP))
            begin
                if (phase_reg == PHASE_EXP)
                begin
                    flags_next.multi_exp = 1'b1;
                end
                else
                begin
                    phase_next = PHASE_EXP;
                end
            end
            else if (phase_reg == PHASE_EXP)
            begin
                priority if ((exp_cnt_reg == 2'd0) && (in_char_reg == CH_MINUS))
                begin
                    exp_neg_next = 1'b1;
                end
                else if (is_digit)
                begin
                    if (!flags_reg.bad_exp)
                    begin
                        if (exp_fits)
                        begin
                            exp_mag_next = exp_x10[EXP_W-1:0];
                        end
                        else
                        begin
                            flags_next.bad_exp = 1'b1;
                        end
                    end
                end
                else
                begin
                    flags_next.bad_exp = 1'b1;
                end
                exp_cnt_next = exp_cnt_inc;
            end
            else if ((in_char_reg == CH_POINT) && (phase_reg == PHASE_INT))
            begin
                phase_next = PHASE_FRAC;
                point_next = 1'b1;
            end
            else
            begin
                if (phase_reg == PHASE_INT)
                begin
                    int_nz_next = 1'b1;
                end
                else
                begin
                    frac_next = frac_inc;
                end

                priority if (in_char_reg == CH_POINT)
                begin
                    flags_next.multi_point = 1'b1;
                end
                else if (!is_digit)
                begin
                    flags_next.nondigit = 1'b1;
                end
                else if (!coef_ovf_reg)
                begin
                    if (coef_fits)
                    begin
                        coef_next = coef_x10[COEF_W-1:0];
                    end
                    else
                    begin
                        coef_ovf_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg    <= 1'b1;
            phase_reg    <= PHASE_INT;
            point_reg    <= 1'b0;
            int_nz_reg   <= 1'b0;
            frac_reg     <= '0;
            coef_reg     <= '0;
            coef_ovf_reg <= 1'b0;
            exp_mag_reg  <= '0;
            exp_neg_reg  <= 1'b0;
            exp_cnt_reg  <= 2'd0;
            flags_reg    <= '0;
        end
        else if (upd_fire)
        begin
            if (upd_ends)
            begin
                // The literal is closed: start the next one from scratch.
                first_reg    <= 1'b1;
                phase_reg    <= PHASE_INT;
                point_reg    <= 1'b0;
                int_nz_reg   <= 1'b0;
                frac_reg     <= '0;
                coef_reg     <= '0;
                coef_ovf_reg <= 1'b0;
                exp_mag_reg  <= '0;
                exp_neg_reg  <= 1'b0;
                exp_cnt_reg  <= 2'd0;
                flags_reg    <= '0;
            end
            else
            begin
                first_reg    <= first_next;
                phase_reg    <= phase_next;
                point_reg    <= point_next;
                int_nz_reg   <= int_nz_next;
                frac_reg     <= frac_next;
                coef_reg     <= coef_next;
                coef_ovf_reg <= coef_ovf_next;
                exp_mag_reg  <= exp_mag_next;
                exp_neg_reg  <= exp_neg_next;
                exp_cnt_reg  <= exp_cnt_next;
                flags_reg    <= flags_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Finish stage: hold the closed literal until the result register frees.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (fin_free)
        begin
            fin_valid_reg <= upd_fire && upd_ends;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire && upd_ends)
        begin
            fin_first_reg    <= first_next;
            fin_phase_reg    <= phase_next;
            fin_point_reg    <= point_next;
            fin_int_nz_reg   <= int_nz_next;
            fin_frac_reg     <= frac_next;
            fin_coef_reg     <= coef_next;
            fin_coef_ovf_reg <= coef_ovf_next;
            fin_exp_mag_reg  <= exp_mag_next;
            fin_exp_neg_reg  <= exp_neg_next;
            fin_exp_cnt_reg  <= exp_cnt_next;
            fin_flags_reg    <= flags_next;
            fin_zero_reg     <= in_zero_reg;
        end
    end

    logic [EXP_W-1:0]        explicit_exp;
    logic signed [EXP_W:0]   exp_diff;
    logic                    exp_in_range;
    dlp_err_t                fin_err;
    logic [COEF_W-1:0]       fin_coef;
    logic signed [EXP_W-1:0] fin_exp;

    // Two's complement of the magnitude covers the most negative value too.
    assign explicit_exp = fin_exp_neg_reg ? (~fin_exp_mag_reg + 1'b1) : fin_exp_mag_reg;
    assign exp_diff = $signed({explicit_exp[EXP_W-1], explicit_exp})
                    - $signed({{(EXP_W+1-COUNT_BITS){1'b0}}, fin_frac_reg});
    assign exp_in_range = (exp_diff[EXP_W] == exp_diff[EXP_W-1]);

    always_comb
    begin
        fin_err  = ERR_OK;
        fin_coef = '0;
        fin_exp  = '0;
        priority if (fin_first_reg || fin_flags_reg.sign)
        begin
            fin_err = ERR_EMPTY_SIGN;
        end
        else if (fin_flags_reg.multi_exp)
        begin
            fin_err = ERR_MULTI_EXP;
        end
        else if ((fin_phase_reg == PHASE_EXP) && (fin_exp_cnt_reg != 2'd0)
                 && (fin_flags_reg.bad_exp
                     || (fin_exp_neg_reg && (fin_exp_cnt_reg == EXP_CNT_ONE))))
        begin
            fin_err = ERR_BAD_EXP;
        end
        else if ((fin_phase_reg == PHASE_EXP) && (fin_exp_cnt_reg == 2'd0))
        begin
            fin_err = ERR_EMPTY_EXP;
        end
        else if (fin_flags_reg.multi_point)
        begin
            fin_err = ERR_MULTI_POINT;
        end
        else if (!fin_int_nz_reg || (fin_point_reg && (fin_frac_reg == '0)))
        begin
            fin_err = ERR_INCOMPLETE;
        end
        else if (fin_flags_reg.nondigit)
        begin
            fin_err = ERR_NONDIGIT;
        end
        else if (!fin_coef_ovf_reg && (fin_coef_reg == '0))
        begin
            // An all-zero value reports zero for both fields when allowed.
            fin_err = fin_zero_reg ? ERR_OK : ERR_ZERO;
        end
        else if (fin_coef_ovf_reg)
        begin
            fin_err = ERR_COEF_RANGE;
        end
        else if (!exp_in_range)
        begin
            fin_err = ERR_EXP_RANGE;
        end
        else
        begin
            fin_err  = ERR_OK;
            fin_coef = fin_coef_reg;
            fin_exp  = exp_diff[EXP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid_reg && out_free)
        begin
            res_err_reg  <= fin_err;
            res_coef_reg <= fin_coef;
            res_exp_reg  <= fin_exp;
        end
    end

    assign results.valid       = res_valid_reg;
    assign results.err_code    = res_err_reg;
    assign results.coefficient = res_coef_reg;
    assign results.exponent    = res_exp_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    logic lit_closed;
    logic parse_clear;
    logic fin_stall;
    logic fin_is_err;
    logic fin_zeroed;

    assign lit_closed  = upd_fire && upd_ends;
    assign parse_clear = first_reg && (phase_reg == PHASE_INT) && (flags_reg == '0)
                         && (coef_reg == '0);
    assign fin_stall   = fin_valid_reg && !out_free;
    assign fin_is_err  = fin_valid_reg && (fin_err != ERR_OK);
    assign fin_zeroed  = (fin_coef == '0) && (fin_exp == '0);

    `DLP_ASSERT_NEXT(a_state_clears, clk, rst_n, lit_closed, parse_clear)
    `DLP_ASSERT_NEXT(a_fin_holds, clk, rst_n, fin_stall, fin_valid_reg && $stable(fin_coef_reg))
    `DLP_ASSERT_NEXT(a_flags_hold, clk, rst_n, fin_stall, $stable(fin_flags_reg))
    `DLP_ASSERT_NOW(a_error_zeroes, clk, rst_n, fin_is_err, fin_zeroed)

endmodule

[tb/sv/tb_decimal_literal_parser_top.sv]
// ----------------------------------------------------------------------------
// Decimal literal parser testbench
// Streams directed and random literals into the parser, one character beat
// at a time, and predicts each literal's value or error code. Every result
// beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_decimal_literal_parser_top;
    import dlp_pkg::*;

    // Run limits.
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_BEATS   = 1460;
    localparam int HOLDOFF_AT     = 700;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [63:0] I64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64_MIN_MAG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] COUNT_MAX   = (64'd1 << DLP_COUNT_BITS) - 64'd1;
    localparam longint      LONG_MIN    = longint'(64'h8000_0000_0000_0000);

    // One beat on the character channel.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic              is_empty;
        logic              zero_allowed;
    } char_beat_t;

    // What one finished literal should produce.
    typedef struct {
        dlp_err_t                code;
        logic [COEF_W-1:0]       coef;
        logic signed [EXP_W-1:0] expo;
    } literal_result_t;

    // The receiver cycles through these ready patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } stall_mode_t;

    logic clk;
    logic rst_n;

    dlp_char_if   chars_if ();
    dlp_result_if results_if ();

    decimal_literal_parser_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    // Stimulus and scoreboard storage.
    char_beat_t      char_beats[$];
    literal_result_t expected_literals[$];
    logic [7:0]      lit_text[$];

    int fail_count     = 0;
    int cycles         = 0;
    int beats_accepted = 0;
    int holdoff_left;
    bit holdoff_done;
    int burst_left;
    int gap_left;
    bit rx_pick;
    char_beat_t      next_beat;
    literal_result_t want;

    // Predictor state for the literal that is streaming in.
    bit          lit_first;
    dlp_phase_t  lit_phase;
    bit          lit_seen_point;
    bit          lit_int_started;
    logic [63:0] lit_frac_cnt;
    logic [63:0] lit_coef;
    bit          lit_coef_ovf;
    logic [63:0] lit_exp_mag;
    bit          lit_exp_neg;
    logic [63:0] lit_exp_cnt;
    dlp_flags_t  lit_flags;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void clear_literal();
        lit_first       = 1'b1;
        lit_phase       = PHASE_INT;
        lit_seen_point  = 1'b0;
        lit_int_started = 1'b0;
        lit_frac_cnt    = '0;
        lit_coef        = '0;
        lit_coef_ovf    = 1'b0;
        lit_exp_mag     = '0;
        lit_exp_neg     = 1'b0;
        lit_exp_cnt     = '0;
        lit_flags       = '0;
    endfunction

    // Character counters stop at the top of their range.
    function automatic logic [63:0] bump_count(logic [63:0] count);
        return (count >= COUNT_MAX) ? COUNT_MAX : count + 64'd1;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        bit          digit;
        logic [63:0] d;
        logic [63:0] lim;
        digit = (c >= CH_0) && (c <= CH_9);
        d     = digit ? 64'(c - CH_0) : 64'd0;
        if (lit_first)
        begin
            lit_first = 1'b0;
            if (c == CH_PLUS || c == CH_MINUS)
                lit_flags.sign = 1'b1;
        end
        if (c == CH_E_LO || c == CH_E_UP)
        begin
            if (lit_phase == PHASE_EXP)
                lit_flags.multi_exp = 1'b1;
            else
                lit_phase = PHASE_EXP;
        end
        else if (lit_phase == PHASE_EXP)
        begin
            // A minus sign is only legal as the first exponent character.
            if (lit_exp_cnt == 0 && c == CH_MINUS)
                lit_exp_neg = 1'b1;
            else if (digit)
            begin
                if (!lit_flags.bad_exp)
                begin
                    lim = lit_exp_neg ? I64_MIN_MAG : I64_MAX;
                    if (lit_exp_mag > (lim - d) / 64'd10)
                        lit_flags.bad_exp = 1'b1;
                    else
                        lit_exp_mag = lit_exp_mag * 64'd10 + d;
                end
            end
            else
                lit_flags.bad_exp = 1'b1;
            lit_exp_cnt = bump_count(lit_exp_cnt);
        end
        else if (c == CH_POINT && lit_phase == PHASE_INT)
        begin
            lit_phase      = PHASE_FRAC;
            lit_seen_point = 1'b1;
        end
        else
        begin
            if (lit_phase == PHASE_INT)
                lit_int_started = 1'b1;
            else
                lit_frac_cnt = bump_count(lit_frac_cnt);
            if (c == CH_POINT)
                lit_flags.multi_point = 1'b1;
            else if (!digit)
                lit_flags.nondigit = 1'b1;
            else if (!lit_coef_ovf)
            begin
                if (lit_coef > (I64_MAX - d) / 64'd10)
                    lit_coef_ovf = 1'b1;
                else
                    lit_coef = lit_coef * 64'd10 + d;
            end
        end
    endfunction

    // Ranks the errors of the finished literal, queues its result and starts
    // a fresh literal.
    function automatic void close_literal(bit zero_ok);
        literal_result_t r;
        longint          explicit_exp;
        longint          frac;
        r.code = ERR_OK;
        r.coef = '0;
        r.expo = '0;
        if (lit_first || lit_flags.sign)
            r.code = ERR_EMPTY_SIGN;
        else if (lit_flags.multi_exp)
            r.code = ERR_MULTI_EXP;
        else if (lit_phase == PHASE_EXP && lit_exp_cnt != 0 &&
                 (lit_flags.bad_exp || (lit_exp_neg && lit_exp_cnt == 64'd1)))
            r.code = ERR_BAD_EXP;
        else if (lit_phase == PHASE_EXP && lit_exp_cnt == 0)
            r.code = ERR_EMPTY_EXP;
        else if (lit_flags.multi_point)
            r.code = ERR_MULTI_POINT;
        else if (!lit_int_started || (lit_seen_point && lit_frac_cnt == 0))
            r.code = ERR_INCOMPLETE;
        else if (lit_flags.nondigit)
            r.code = ERR_NONDIGIT;
        else if (!lit_coef_ovf && lit_coef == 0)
            r.code = zero_ok ? ERR_OK : ERR_ZERO;
        else if (lit_coef_ovf)
            r.code = ERR_COEF_RANGE;
        else
        begin
            if (lit_exp_neg && lit_exp_mag != 0)
                explicit_exp = -longint'(lit_exp_mag - 64'd1) - 1;
            else
                explicit_exp = longint'(lit_exp_mag & I64_MAX);
            frac = longint'(lit_frac_cnt);
            if (explicit_exp < LONG_MIN + frac)
                r.code = ERR_EXP_RANGE;
            else
            begin
                r.coef = lit_coef[COEF_W-1:0];
                r.expo = explicit_exp - frac;
            end
        end
        expected_literals.insert(expected_literals.size(), r);
        clear_literal();
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------

    task automatic add_char(logic [7:0] c);
        lit_text.insert(lit_text.size(), c);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic add_digits(int n);
        for (int i = 0; i < n; i++)
            add_char(8'(CH_0 + $urandom_range(0, 9)));
    endtask

    // Turns the text gathered so far into beats. A literal may be closed by
    // an extra empty beat instead of a last flag on its final character.
    task automatic emit_literal(bit zero_ok, bit close_empty);
        char_beat_t b;
        if (lit_text.size() == 0)
            close_empty = 1'b1;
        for (int i = 0; i < lit_text.size(); i++)
        begin
            b.char_code    = lit_text[i];
            b.is_empty     = 1'b0;
            b.is_last      = (i == lit_text.size() - 1) && !close_empty;
            b.zero_allowed = b.is_last ? zero_ok : 1'($urandom_range(0, 1));
            char_beats.insert(char_beats.size(), b);
        end
        if (close_empty)
        begin
            b.char_code    = 8'($urandom_range(0, 255));
            b.is_empty     = 1'b1;
            b.is_last      = 1'($urandom_range(0, 1));
            b.zero_allowed = zero_ok;
            char_beats.insert(char_beats.size(), b);
        end
        lit_text.delete();
    endtask

    task automatic directed(string s, bit zero_ok);
        add_text(s);
        emit_literal(zero_ok, 1'b0);
    endtask

    task automatic random_literal();
        int    kind;
        int    pos;
        string edge_txt[4];
        edge_txt[0] = "9223372036854775807";
        edge_txt[1] = "9223372036854775808";
        edge_txt[2] = "-9223372036854775808";
        edge_txt[3] = "-9223372036854775809";
        kind = $urandom_range(0, 99);
        if (kind < 4)
        begin
            emit_literal(1'($urandom_range(0, 1)), 1'b1);
            return;
        end
        if (kind < 12)
        begin
            // Raw byte noise.
            repeat ($urandom_range(1, 8))
                add_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Well-formed skeleton: integer, optional fraction, optional exponent.
            case ($urandom_range(0, 19))
                0:       add_text(edge_txt[$urandom_range(0, 1)]);
                1:       repeat ($urandom_range(1, 4)) add_char(CH_0);
                2:       add_digits($urandom_range(15, 21));
                default: add_digits($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                add_char(CH_POINT);
                if ($urandom_range(0, 9) != 0)
                    add_digits($urandom_range(1, 5));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                add_char($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
                case ($urandom_range(0, 11))
                    0:       add_text(edge_txt[$urandom_range(0, 3)]);
                    1:       ;
                    default:
                    begin
                        if ($urandom_range(0, 2) == 0)
                            add_char(CH_MINUS);
                        add_digits($urandom_range(1, 4));
                    end
                endcase
            end
            // Some skeletons get broken by one inserted or dropped character.
            if (kind < 30)
            begin
                pos = $urandom_range(0, lit_text.size());
                case ($urandom_range(0, 6))
                    0: lit_text.insert(pos, CH_PLUS);
                    1: lit_text.insert(pos, CH_MINUS);
                    2: lit_text.insert(pos, CH_POINT);
                    3: lit_text.insert(pos, CH_E_LO);
                    4: lit_text.insert(pos, CH_E_UP);
                    5: lit_text.insert(pos, 8'($urandom_range(0, 255)));
                    default:
                        if (lit_text.size() > 1)
                            lit_text.delete(pos % lit_text.size());
                endcase
            end
        end
        emit_literal(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The drop from X to zero at time zero also resets the testbench drivers.
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Character driver: sends queued beats in bursts with random gaps.
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_if.valid        <= 1'b0;
            chars_if.char_code    <= '0;
            chars_if.is_last      <= 1'b0;
            chars_if.is_empty     <= 1'b0;
            chars_if.zero_allowed <= 1'b0;
            burst_left            <= $urandom_range(1, 24);
            gap_left              <= 0;
        end
        else if (!chars_if.valid || chars_if.ready)
        begin
            if (gap_left != 0)
            begin
                chars_if.valid <= 1'b0;
                gap_left       <= gap_left - 1;
            end
            else if (char_beats.size() != 0)
            begin
                next_beat = char_beats.pop_front();
                chars_if.valid        <= 1'b1;
                chars_if.char_code    <= next_beat.char_code;
                chars_if.is_last      <= next_beat.is_last;
                chars_if.is_empty     <= next_beat.is_empty;
                chars_if.zero_allowed <= next_beat.zero_allowed;
                // At the end of a burst, a third of the gaps are zero so that
                // long unbroken runs of beats occur as well.
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                chars_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: a rotating stall pattern plus one long hold-off that
    // lets the parser back up into its character input.
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else if (!holdoff_done && beats_accepted >= HOLDOFF_AT)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_if.ready <= 1'b0;
        else
        begin
            case (stall_mode_t'(cycles[8:7]))
                RX_OPEN:  rx_pick = 1'b1;
                RX_LIGHT: rx_pick = $urandom_range(0, 3) != 0;
                RX_HEAVY: rx_pick = $urandom_range(0, 3) == 0;
                default:  rx_pick = cycles[2:0] != 3'd0;
            endcase
            results_if.ready <= rx_pick && (holdoff_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: predicts on every accepted character beat and checks every
    // accepted result beat against the oldest prediction.
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            if (!chars_if.is_empty)
                parse_char(chars_if.char_code);
            // An empty beat closes the literal even without the last flag.
            if (chars_if.is_last || chars_if.is_empty)
                close_literal(chars_if.zero_allowed);
            beats_accepted <= beats_accepted + 1;
        end
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (expected_literals.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("Unexpected result beat: code %0d coef %0d exp %0d",
                             results_if.err_code, results_if.coefficient,
                             results_if.exponent);
            end
            else
            begin
                want = expected_literals.pop_front();
                if (results_if.err_code !== want.code ||
                    results_if.coefficient !== want.coef ||
                    results_if.exponent !== want.expo)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("Result mismatch: expected code %0d coef %0d exp %0d",
                                 want.code, want.coef, want.expo);
                        $display("                 got code %0d coef %0d exp %0d",
                                 results_if.err_code, results_if.coefficient,
                                 results_if.exponent);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int start_beats;
        clear_literal();

        // Directed literals, at least one per error class plus the value extremes.
        directed("", 1'b0);                               // empty literal
        directed("+5", 1'b0);                             // leading plus
        directed("-5", 1'b1);                             // leading minus
        directed("1e2e3", 1'b0);                          // two exponent marks
        directed("1e+3", 1'b0);                           // plus inside exponent
        directed("1e-", 1'b0);                            // lone exponent minus
        directed("1E9223372036854775808", 1'b0);          // exponent too large
        directed("1e", 1'b0);                             // empty exponent
        directed("1.2.3", 1'b0);                          // two points
        directed(".5", 1'b0);                             // no integer digits
        directed("5.", 1'b0);                             // point with no fraction
        directed("e5", 1'b0);                             // exponent only
        add_text("7");
        add_char(8'hFF);
        emit_literal(1'b0, 1'b0);                         // nondigit, top byte
        add_char(8'h00);
        emit_literal(1'b1, 1'b0);                         // nondigit, bottom byte
        directed("000", 1'b0);                            // zero rejected
        directed("0.00e5", 1'b1);                         // zero accepted
        directed("9223372036854775807", 1'b0);            // largest coefficient
        directed("9223372036854775808", 1'b0);            // coefficient overflow
        directed("1.5e-9223372036854775808", 1'b0);       // exponent underflow
        directed("1e-9223372036854775808", 1'b0);         // smallest exponent
        directed("1e9223372036854775807", 1'b0);          // largest exponent
        directed("12.345E-7", 1'b0);
        add_text("0007.50e12");
        emit_literal(1'b0, 1'b1);                         // closed by empty beat

        // Random literals until enough character beats are queued.
        start_beats = char_beats.size();
        while (char_beats.size() - start_beats < RANDOM_BEATS)
            random_literal();

        @(posedge rst_n);
        while (char_beats.size() != 0 || chars_if.valid)
            @(negedge clk);
        while (expected_literals.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_literals.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[decimal_literal_parser_top.f]
+incdir+rtl/core
rtl/core/dlp_pkg.sv
rtl/core/dlp_char_if.sv
rtl/core/dlp_result_if.sv
rtl/core/decimal_literal_parser_top.sv
tb/sv/tb_decimal_literal_parser_top.sv
